// ===== rtl/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants and the UTF-8 byte formatter of the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u8_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned HELD_W      = 10;
  localparam int unsigned LEN_W       = 3;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [UNIT_W-1:0] HIGH_FIRST  = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_LAST   = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_FIRST   = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_LAST    = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h10000;
  localparam logic [CP_W-1:0]   REPLACEMENT = 21'h0FFFD;
  localparam logic [UNIT_W-1:0] ONE_BYTE_LIM = 16'h0080;
  localparam logic [UNIT_W-1:0] TWO_BYTE_LIM = 16'h0800;

  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

  // One queued piece of work: an optional replacement character for a
  // dropped high surrogate, then a code point of len bytes (none if zero).
  typedef struct packed {
    logic             pre_fffd;
    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  cp;
    logic             is_final;
  } job_t;

  // Byte idx of the len-byte UTF-8 form of cp.
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [LEN_W-1:0] len,
                                           input logic [IDX_W-1:0] idx);
    logic [LEN_W-1:0] pos;
    logic [7:0]       res;
    pos = len - LEN_1 - {1'b0, idx};
    if (idx == '0) begin
      unique case (len)
        LEN_2:   res = LEAD2_MARK | {3'b000, cp[10:6]};
        LEN_3:   res = LEAD3_MARK | {4'b0000, cp[15:12]};
        LEN_4:   res = LEAD4_MARK | {5'b00000, cp[20:18]};
        default: res = {1'b0, cp[6:0]};
      endcase
    end else begin
      unique case (pos)
        3'd0:    res = CONT_MARK | (CONT_MASK & {2'b00, cp[5:0]});
        3'd1:    res = CONT_MARK | (CONT_MASK & {2'b00, cp[11:6]});
        3'd2:    res = CONT_MARK | (CONT_MASK & {2'b00, cp[17:12]});
        default: res = CONT_MARK | (CONT_MASK & {5'b00000, cp[20:18]});
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and U+FFFD
// replacement of lone surrogates.
// ----------------------------------------------------------------------------
// The first byte of a unit passes through the queue and then through the
// registered output stage before it is on the output.
// The byte emitter gives one output byte per cycle while the queue holds a
// job and out_ready is high; a unit yields zero to six bytes, and a held high
// surrogate with no dropped one before it yields none. Reset clears the
// surrogate hold, the queue and the output stage.
`default_nettype none

module utf16_to_utf8_transcoder
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [UNIT_W-1:0] in_code_unit,
  input  wire logic              in_unit_is_final,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_run_end,
  output logic                   out_string_end
);

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, head_job;

  u2u8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_unit     (in_code_unit),
    .in_unit_is_final (in_unit_is_final),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (push_job)
  );

  u2u8_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  u2u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire

// ===== rtl/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// u2u8_front
// Takes code units, pairs surrogates and pushes encode jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_front
  import u2u8_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [UNIT_W-1:0] in_code_unit,
  input  wire logic              in_unit_is_final,
  input  wire logic              q_full,
  output logic                   q_push,
  output job_t                   q_job
);

  logic              high_pending_r, high_pending_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic              accept, is_high, is_low;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (in_code_unit >= HIGH_FIRST) && (in_code_unit <= HIGH_LAST);
  assign is_low   = (in_code_unit >= LOW_FIRST) && (in_code_unit <= LOW_LAST);

  always_comb begin
    high_pending_nxt = high_pending_r;
    held_nxt         = held_r;
    q_job.pre_fffd   = 1'b0;
    q_job.len        = LEN_NONE;
    q_job.cp         = REPLACEMENT;
    q_job.is_final   = in_unit_is_final;
    if (high_pending_r && is_low) begin
      q_job.cp         = SUPP_BASE + {1'b0, held_r, in_code_unit[HELD_W-1:0]};
      q_job.len        = LEN_4;
      high_pending_nxt = 1'b0;
    end else begin
      q_job.pre_fffd   = high_pending_r;
      high_pending_nxt = 1'b0;
      if (is_high && !in_unit_is_final) begin
        high_pending_nxt = 1'b1;
        held_nxt         = in_code_unit[HELD_W-1:0];
      end else if (is_high || is_low) begin
        q_job.len = LEN_3;
      end else begin
        q_job.cp = {{(CP_W-UNIT_W){1'b0}}, in_code_unit};
        if (in_code_unit < ONE_BYTE_LIM) begin
          q_job.len = LEN_1;
        end else if (in_code_unit < TWO_BYTE_LIM) begin
          q_job.len = LEN_2;
        end else begin
          q_job.len = LEN_3;
        end
      end
    end
  end

  // A held high surrogate with nothing before it produces no job.
  assign q_push = accept && (q_job.pre_fffd || (q_job.len != LEN_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pending_r <= 1'b0;
      held_r         <= '0;
    end else if (accept) begin
      high_pending_r <= high_pending_nxt;
      held_r         <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// u2u8_queue
// Short job queue between the front and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// u2u8_back
// Walks the head job byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u8_back
  import u2u8_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t head_job,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_byte,
  output logic      out_run_end,
  output logic      out_string_end
);

  logic             out_valid_r;
  logic [7:0]       byte_r;
  logic             run_end_r, string_end_r;
  logic             pre_done_r;
  logic [IDX_W-1:0] idx_r;

  logic             load, in_pre, last_of_cp, last_of_job;
  logic [CP_W-1:0]  cur_cp;
  logic [LEN_W-1:0] cur_len;

  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign in_pre  = head_job.pre_fffd && !pre_done_r;
  assign cur_cp  = in_pre ? REPLACEMENT : head_job.cp;
  assign cur_len = in_pre ? LEN_3 : head_job.len;

  assign last_of_cp  = ({1'b0, idx_r} == (cur_len - LEN_1));
  assign last_of_job = last_of_cp && (!in_pre || (head_job.len == LEN_NONE));
  assign q_pop       = load && last_of_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pre_done_r  <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        if (last_of_job) begin
          idx_r      <= '0;
          pre_done_r <= 1'b0;
        end else if (last_of_cp) begin
          idx_r      <= '0;
          pre_done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= utf8_byte(cur_cp, cur_len, idx_r);
      run_end_r    <= last_of_job;
      string_end_r <= last_of_job && head_job.is_final;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_run_end    = run_end_r;
  assign out_string_end = string_end_r;

endmodule

`default_nettype wire
